### hdl/mgm_pkg.sv
// ----------------------------------------------------------------------------
// mgm_pkg
// Shared types, codes, S-box table, round function and byte mask for the Magma unit.
// ----------------------------------------------------------------------------
package mgm_pkg;

    localparam int NUM_ROUNDS    = 32;
    localparam int NUM_KEYS      = 8;
    localparam int HALF_W        = 32;
    localparam int BLOCK_W       = 64;
    localparam int ROT_LEFT      = 11;
    localparam int FWD_ROUNDS_ENC = 24;
    localparam int FWD_ROUNDS_DEC = 8;
    localparam int CFG_IDX_W     = 3;

    // operation codes
    localparam logic [1:0] OP_ENCRYPT = 2'd0;
    localparam logic [1:0] OP_DECRYPT = 2'd1;
    localparam logic [1:0] OP_CTR     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEYS_0_1   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYS_2_3   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYS_4_5   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYS_6_7   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_IV = 3'd4;

    typedef logic [NUM_KEYS-1:0][HALF_W-1:0] t_keys;

    // what travels alongside the block through the round cells
    typedef struct packed {
        logic [1:0]         op;
        logic [BLOCK_W-1:0] data;
        logic [3:0]         nbytes;
    } t_side;

    localparam logic [3:0] SBOX [8][16] = '{
        '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
          4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1},
        '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
          4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
        '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
          4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
        '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
          4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
        '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
          4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
        '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
          4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
        '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
          4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
        '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
          4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2}
    };

    // key add, substitution, rotate left by 11
    function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] half,
                                                   input logic [HALF_W-1:0] key);
        logic [HALF_W-1:0] t;
        logic [HALF_W-1:0] s;
        t = half + key;
        for (int n = 0; n < 8; n++) begin
            s[4*n +: 4] = SBOX[n][t[4*n +: 4]];
        end
        return {s[HALF_W-ROT_LEFT-1:0], s[HALF_W-1:HALF_W-ROT_LEFT]};
    endfunction

    // keep the low nbytes bytes, at least eight treated as all
    function automatic logic [BLOCK_W-1:0] byte_mask(input logic [3:0] nbytes);
        logic [BLOCK_W-1:0] m;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = ((nbytes[3] == 1'b1) || (nbytes[2:0] > 3'(i))) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

### hdl/mgm_round_cell.sv
// ----------------------------------------------------------------------------
// mgm_round_cell
// One Feistel round with its own register stage; hands the block on each beat.
// ----------------------------------------------------------------------------
module mgm_round_cell #(
    parameter int ROUND = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mgm_pkg::t_keys               i_keys,
    input  logic                         i_valid,
    input  logic [mgm_pkg::HALF_W-1:0]   i_lo,
    input  logic [mgm_pkg::HALF_W-1:0]   i_hi,
    input  mgm_pkg::t_side               i_side,
    output logic                         o_take,
    input  logic                         i_take_next,
    output logic                         o_valid,
    output logic [mgm_pkg::HALF_W-1:0]   o_lo,
    output logic [mgm_pkg::HALF_W-1:0]   o_hi,
    output mgm_pkg::t_side               o_side
);

    localparam int ENC_IDX = (ROUND < mgm_pkg::FWD_ROUNDS_ENC) ?
                             (ROUND % mgm_pkg::NUM_KEYS) :
                             (mgm_pkg::NUM_KEYS - 1 - (ROUND % mgm_pkg::NUM_KEYS));
    localparam int DEC_IDX = (ROUND < mgm_pkg::FWD_ROUNDS_DEC) ?
                             (ROUND % mgm_pkg::NUM_KEYS) :
                             (mgm_pkg::NUM_KEYS - 1 - (ROUND % mgm_pkg::NUM_KEYS));
    localparam bit LAST = (ROUND == mgm_pkg::NUM_ROUNDS - 1);

    logic                       r_valid;
    logic [mgm_pkg::HALF_W-1:0] r_lo;
    logic [mgm_pkg::HALF_W-1:0] r_hi;
    mgm_pkg::t_side             r_side;
    logic [mgm_pkg::HALF_W-1:0] n_lo;
    logic [mgm_pkg::HALF_W-1:0] n_hi;
    logic [mgm_pkg::HALF_W-1:0] key;
    logic [mgm_pkg::HALF_W-1:0] t;

    assign o_take = !r_valid || i_take_next;

    always_comb begin
        key = (i_side.op == mgm_pkg::OP_DECRYPT) ? i_keys[DEC_IDX] : i_keys[ENC_IDX];
        t   = mgm_pkg::round_fn(i_lo, key) ^ i_hi;
        if (LAST) begin
            // no swap after the final round
            n_lo = i_lo;
            n_hi = t;
        end else begin
            n_lo = t;
            n_hi = i_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
    assign o_side  = r_side;

endmodule

### hdl/magma_block_cipher_ecb_ctr_unit.sv
// ----------------------------------------------------------------------------
// magma_block_cipher_ecb_ctr_unit
// Magma (GOST R 34.12-2015) 64-bit block cipher, ECB encrypt/decrypt and CTR.
// ----------------------------------------------------------------------------
// One block is accepted per cycle while o_in_stall is low. Each block
// passes a chain of 32 registered round cells and then an output register;
// throughput is one block per cycle unless the output side stalls. A stall
// holds only the full stages behind it, so empty stages keep filling. Round
// keys and the counter IV must be written through the configuration port
// only while no block is in flight; the unit does not enforce this. In
// counter mode the counter is read (or reloaded from the IV) and advanced
// on the input beat, so successive counter blocks follow in input order.
module magma_block_cipher_ecb_ctr_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mgm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mgm_pkg::BLOCK_W-1:0]         i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_operation,
    input  logic [mgm_pkg::BLOCK_W-1:0]         i_data_in,
    input  logic                                i_restart,
    input  logic [3:0]                          i_valid_bytes,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mgm_pkg::BLOCK_W-1:0]         o_data_out
);

    localparam int N = mgm_pkg::NUM_ROUNDS;

    mgm_pkg::t_keys              r_keys;
    logic [mgm_pkg::HALF_W-1:0]  r_iv;
    logic [mgm_pkg::BLOCK_W-1:0] r_ctr;
    logic                        r_out_valid;
    logic [mgm_pkg::BLOCK_W-1:0] r_out_data;
    logic [mgm_pkg::BLOCK_W-1:0] n_out_data;

    logic                        in_accept;
    logic                        is_ctr;
    logic [mgm_pkg::BLOCK_W-1:0] ctr_base;
    logic [mgm_pkg::BLOCK_W-1:0] blk;
    logic [mgm_pkg::BLOCK_W-1:0] cipher;

    logic                        c_valid [N+1];
    logic [mgm_pkg::HALF_W-1:0]  c_lo    [N+1];
    logic [mgm_pkg::HALF_W-1:0]  c_hi    [N+1];
    mgm_pkg::t_side              c_side  [N+1];
    logic                        c_take  [N+1];

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
            r_iv   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mgm_pkg::CFG_KEYS_0_1: begin
                    r_keys[0] <= i_cfg_data[31:0];
                    r_keys[1] <= i_cfg_data[63:32];
                end
                mgm_pkg::CFG_KEYS_2_3: begin
                    r_keys[2] <= i_cfg_data[31:0];
                    r_keys[3] <= i_cfg_data[63:32];
                end
                mgm_pkg::CFG_KEYS_4_5: begin
                    r_keys[4] <= i_cfg_data[31:0];
                    r_keys[5] <= i_cfg_data[63:32];
                end
                mgm_pkg::CFG_KEYS_6_7: begin
                    r_keys[6] <= i_cfg_data[31:0];
                    r_keys[7] <= i_cfg_data[63:32];
                end
                mgm_pkg::CFG_COUNTER_IV: begin
                    r_iv <= i_cfg_data[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front: pick the block and step the counter on the input beat
    assign in_accept  = i_in_valid && c_take[0];
    assign o_in_stall = !c_take[0];
    assign is_ctr     = (i_operation == mgm_pkg::OP_CTR);
    assign ctr_base   = i_restart ? {r_iv, {mgm_pkg::HALF_W{1'b0}}} : r_ctr;
    assign blk        = is_ctr ? ctr_base : i_data_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
        end else if (in_accept && is_ctr) begin
            r_ctr <= ctr_base + 64'd1;
        end
    end

    assign c_valid[0]       = i_in_valid;
    assign c_lo[0]          = blk[31:0];
    assign c_hi[0]          = blk[63:32];
    assign c_side[0].op     = i_operation;
    assign c_side[0].data   = i_data_in;
    assign c_side[0].nbytes = i_valid_bytes;

    for (genvar g = 0; g < N; g++) begin : g_round
        mgm_round_cell #(
            .ROUND(g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_keys      (r_keys),
            .i_valid     (c_valid[g]),
            .i_lo        (c_lo[g]),
            .i_hi        (c_hi[g]),
            .i_side      (c_side[g]),
            .o_take      (c_take[g]),
            .i_take_next (c_take[g+1]),
            .o_valid     (c_valid[g+1]),
            .o_lo        (c_lo[g+1]),
            .o_hi        (c_hi[g+1]),
            .o_side      (c_side[g+1])
        );
    end

    // output register
    assign c_take[N] = !r_out_valid || !i_out_stall;
    assign cipher    = {c_hi[N], c_lo[N]};

    always_comb begin
        case (c_side[N].op)
            mgm_pkg::OP_ENCRYPT: n_out_data = cipher;
            mgm_pkg::OP_DECRYPT: n_out_data = cipher;
            mgm_pkg::OP_CTR:     n_out_data = cipher ^ c_side[N].data;
            default:             n_out_data = '0;
        endcase
        n_out_data = n_out_data & mgm_pkg::byte_mask(c_side[N].nbytes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_take[N]) begin
            r_out_valid <= c_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_take[N] && c_valid[N]) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;

endmodule
